FILE: rtl/ntt4_pkg.sv
// shared types, constants and reset values for the radix-4 ntt butterfly core
package ntt4_pkg;

  typedef logic [30:0] residue_t;

  // default modulus and floor(2^62 / modulus) that goes with it
  localparam residue_t   PRIME_RESET = 31'd2013265921;
  localparam logic [61:0] MU_RESET   = 62'(64'h4000_0000_0000_0000 / 64'd2013265921);

  // reciprocal division produces quotient bits 61 down to 0
  localparam int unsigned RECIP_STEPS = 62;
  localparam logic [5:0]  RECIP_CNT_INIT = 6'(RECIP_STEPS - 1);

  // pipeline timing: accept edge to done cycle
  localparam int unsigned LATENCY = 14;
  // delay from the first compute stage to the combine stage
  localparam int unsigned UDLY = 7;
  // position in the tag pipeline where mode steers the combine stage
  localparam int unsigned SM_IDX = 8;

  typedef struct packed {
    logic     mode;
    residue_t in_a;
    residue_t in_b;
    residue_t in_c;
    residue_t in_d;
    residue_t twiddle;
    logic     last_group;
  } cmd_t;

  typedef struct packed {
    residue_t out_a;
    residue_t out_b;
    residue_t out_c;
    residue_t out_d;
    logic     out_last;
  } res_t;

  typedef struct packed {
    residue_t    prime;
    logic [61:0] mu;
    logic        trivial;
  } mod_cfg_t;

  typedef struct packed {
    logic        neg;
    logic [32:0] mag;
  } smag_t;

  typedef struct packed {
    logic signed [31:0] u;
    smag_t              sum;
    smag_t              alt;
  } dly_t;

endpackage

FILE: rtl/ntt_radix4_modular_butterfly_core.sv
// radix-4 modular ntt butterfly core, top level
// done comes from the end of the valid pipeline for every accepted transaction
// throughput: one transaction per cycle while busy is low, set by the fully pipelined barrett reducers
// a prime write holds busy high while the bit-serial reciprocal divider runs
// reset loads the default prime and its reciprocal at once and clears the valid pipeline
// the receiver cannot stall: each result shows on result for one cycle with done high
module ntt_radix4_modular_butterfly_core import ntt4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  cmd_t     cmd,
  output logic     done,
  output res_t     result,
  input  logic     cfg_we,
  input  residue_t cfg_wdata
);

  mod_cfg_t mod_cfg;
  logic     accept;

  // tag pipeline: valid, last flag and mode follow each transaction
  logic [LATENCY-1:0] vld_pipe;
  logic [LATENCY-1:0] last_pipe;
  logic [SM_IDX:0]    mode_pipe;

  // input register
  cmd_t s0;

  // first compute stage
  logic [31:0] pa;
  logic [31:0] pb;
  residue_t    x_u;
  residue_t    y_d;
  logic        dd_neg;
  residue_t    dd_mag;
  logic        alt_neg;
  dly_t        s1_dly_next;
  dly_t        s1_dly;
  residue_t    s1_ddmag;
  logic        s1_ddneg;
  residue_t    s1_tw;

  // product stage
  logic [61:0] prod;
  logic        prod_neg;
  residue_t    tm;

  // delay line and combine stage
  dly_t               dly [UDLY];
  logic signed [33:0] us;
  logic signed [33:0] tms;
  logic signed [33:0] pp;
  logic signed [33:0] pn;
  logic signed [33:0] mp;
  logic signed [33:0] mn;
  smag_t              plus_v;
  smag_t              minus_v;
  logic               mode_sm;
  smag_t              sm_a;
  smag_t              sm_b;
  smag_t              sm_c;
  smag_t              sm_d;

  residue_t ra;
  residue_t rb;
  residue_t rc;
  residue_t rd;

  ntt4_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .mod_cfg   (mod_cfg),
    .busy      (busy)
  );

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_pipe <= '0;
    end else begin
      vld_pipe <= {vld_pipe[LATENCY-2:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    last_pipe <= {last_pipe[LATENCY-2:0], cmd.last_group};
    mode_pipe <= {mode_pipe[SM_IDX-1:0], cmd.mode};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0 <= cmd;
    end
  end

  // pair sums and differences on the raw operands; reduction happens at the end
  // dit pairs (a,b) and (c,d), dif pairs (a,c) and (b,d)
  always_comb begin
    if (s0.mode) begin
      pa  = {1'b0, s0.in_a} + {1'b0, s0.in_c};
      pb  = {1'b0, s0.in_b} + {1'b0, s0.in_d};
      x_u = s0.in_c;
      y_d = s0.in_b;
    end else begin
      pa  = {1'b0, s0.in_a} + {1'b0, s0.in_b};
      pb  = {1'b0, s0.in_c} + {1'b0, s0.in_d};
      x_u = s0.in_b;
      y_d = s0.in_c;
    end
    dd_neg  = (s0.in_d > y_d);
    dd_mag  = dd_neg ? (s0.in_d - y_d) : (y_d - s0.in_d);
    alt_neg = (pb > pa);
    s1_dly_next.u       = $signed({1'b0, s0.in_a} - {1'b0, x_u});
    s1_dly_next.sum.neg = 1'b0;
    s1_dly_next.sum.mag = {1'b0, pa} + {1'b0, pb};
    s1_dly_next.alt.neg = alt_neg;
    s1_dly_next.alt.mag = {1'b0, (alt_neg ? (pb - pa) : (pa - pb))};
  end

  always_ff @(posedge clk) begin
    s1_dly   <= s1_dly_next;
    s1_ddmag <= dd_mag;
    s1_ddneg <= dd_neg;
    s1_tw    <= s0.twiddle;
  end

  // twiddle product on the difference magnitude
  always_ff @(posedge clk) begin
    prod     <= {31'd0, s1_ddmag} * {31'd0, s1_tw};
    prod_neg <= s1_ddneg;
  end

  ntt4_red_wide u_red_wide (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .mag     (prod),
    .neg     (prod_neg),
    .res     (tm)
  );

  // hold the other terms until the reduced product arrives
  always_ff @(posedge clk) begin
    dly[0] <= s1_dly;
    for (int i = 1; i < UDLY; i++) begin
      dly[i] <= dly[i-1];
    end
  end

  // u plus and minus the reduced product, both signs in parallel
  always_comb begin
    us  = {{2{dly[UDLY-1].u[31]}}, dly[UDLY-1].u};
    tms = {3'd0, tm};
    pp  = us + tms;
    pn  = 34'sd0 - us - tms;
    mp  = us - tms;
    mn  = tms - us;
    plus_v.neg  = pp[33];
    plus_v.mag  = pp[33] ? pn[32:0] : pp[32:0];
    minus_v.neg = mp[33];
    minus_v.mag = mp[33] ? mn[32:0] : mp[32:0];
    mode_sm = mode_pipe[SM_IDX];
  end

  // steer into output slots: dif swaps the alternating sum and the plus term
  always_ff @(posedge clk) begin
    sm_a <= dly[UDLY-1].sum;
    sm_b <= mode_sm ? dly[UDLY-1].alt : plus_v;
    sm_c <= mode_sm ? plus_v : dly[UDLY-1].alt;
    sm_d <= minus_v;
  end

  ntt4_red_small u_red_a (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .val     (sm_a),
    .res     (ra)
  );

  ntt4_red_small u_red_b (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .val     (sm_b),
    .res     (rb)
  );

  ntt4_red_small u_red_c (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .val     (sm_c),
    .res     (rc)
  );

  ntt4_red_small u_red_d (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .val     (sm_d),
    .res     (rd)
  );

  assign done            = vld_pipe[LATENCY-1];
  assign result.out_a    = ra;
  assign result.out_b    = rb;
  assign result.out_c    = rc;
  assign result.out_d    = rd;
  assign result.out_last = last_pipe[LATENCY-1];

  a_latency: assert property (@(posedge clk) disable iff (rst) accept |-> ##LATENCY done)
    else $error("accepted transaction did not produce a result on time");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe without a matching accepted transaction");

  a_trivial_zero: assert property (@(posedge clk) disable iff (rst)
    (done && $past(mod_cfg.trivial)) |->
      (result.out_a == '0) && (result.out_b == '0) &&
      (result.out_c == '0) && (result.out_d == '0))
    else $error("modulus of zero or one gave a nonzero residue");

endmodule

FILE: rtl/ntt4_recip.sv
// prime register and bit-serial reciprocal division for barrett reduction
module ntt4_recip import ntt4_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  residue_t cfg_wdata,
  output mod_cfg_t mod_cfg,
  output logic     busy
);

  logic        running;
  logic [5:0]  cnt;
  residue_t    rem;
  logic [31:0] rem2;
  logic [31:0] rem_diff;
  logic        qbit;

  assign rem2     = {rem, 1'b0};
  assign rem_diff = rem2 - {1'b0, mod_cfg.prime};
  assign qbit     = (rem2 >= {1'b0, mod_cfg.prime});
  assign busy     = running;

  always_ff @(posedge clk) begin
    if (rst) begin
      mod_cfg.prime   <= PRIME_RESET;
      mod_cfg.mu      <= MU_RESET;
      mod_cfg.trivial <= 1'b0;
      running         <= 1'b0;
      cnt             <= '0;
    end else if (cfg_we) begin
      mod_cfg.prime   <= cfg_wdata;
      mod_cfg.trivial <= (cfg_wdata[30:1] == '0);
      running         <= 1'b1;
      cnt             <= RECIP_CNT_INIT;
      rem             <= 31'd1;
    end else if (running) begin
      mod_cfg.mu <= {mod_cfg.mu[60:0], qbit};
      rem        <= qbit ? rem_diff[30:0] : rem2[30:0];
      if (cnt == '0) begin
        running <= 1'b0;
      end else begin
        cnt <= cnt - 6'd1;
      end
    end
  end

  a_write_busy: assert property (@(posedge clk) disable iff (rst) cfg_we |=> busy)
    else $error("reciprocal division did not start after prime write");

  a_div_end: assert property (@(posedge clk) disable iff (rst)
    (running && !cfg_we && cnt == '0) |=> !busy)
    else $error("reciprocal division overran its step count");

  a_cfg_hold: assert property (@(posedge clk) disable iff (rst)
    (!running && !cfg_we) |=> $stable(mod_cfg))
    else $error("modulus settings changed while idle");

endmodule

FILE: rtl/ntt4_red_tail.sv
// barrett tail: subtract quotient times prime, one correction, sign fold, zero for a trivial modulus
module ntt4_red_tail import ntt4_pkg::*; (
  input  logic        clk,
  input  mod_cfg_t    mod_cfg,
  input  logic [31:0] x_lo,
  input  logic [31:0] q,
  input  logic        neg,
  output residue_t    res
);

  logic [62:0] qm_full;
  logic [31:0] qm;
  logic [31:0] x1;
  logic        n1;
  logic [31:0] r;
  logic [31:0] r_sub;
  residue_t    r1;
  logic        n2;

  assign qm_full = {31'd0, q} * {32'd0, mod_cfg.prime};

  always_ff @(posedge clk) begin
    qm <= qm_full[31:0];
    x1 <= x_lo;
    n1 <= neg;
  end

  // remainder estimate is below twice the prime
  assign r     = x1 - qm;
  assign r_sub = r - {1'b0, mod_cfg.prime};

  always_ff @(posedge clk) begin
    r1 <= (r >= {1'b0, mod_cfg.prime}) ? r_sub[30:0] : r[30:0];
    n2 <= n1;
  end

  always_ff @(posedge clk) begin
    if (mod_cfg.trivial) begin
      res <= '0;
    end else if (n2 && (r1 != '0)) begin
      res <= mod_cfg.prime - r1;
    end else begin
      res <= r1;
    end
  end

endmodule

FILE: rtl/ntt4_red_small.sv
// reduction of a signed value below 2^33 in magnitude
module ntt4_red_small import ntt4_pkg::*; (
  input  logic     clk,
  input  mod_cfg_t mod_cfg,
  input  smag_t    val,
  output residue_t res
);

  logic [32:0] mu2;
  logic [65:0] p1;
  logic [31:0] x1;
  logic        n1;

  // floor(2^33 / prime) taken from the wide reciprocal
  assign mu2 = mod_cfg.mu[61:29];

  always_ff @(posedge clk) begin
    p1 <= {33'd0, val.mag} * {33'd0, mu2};
    x1 <= val.mag[31:0];
    n1 <= val.neg;
  end

  ntt4_red_tail u_tail (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .x_lo    (x1),
    .q       (p1[64:33]),
    .neg     (n1),
    .res     (res)
  );

endmodule

FILE: rtl/ntt4_red_wide.sv
// reduction of a signed product below 2^62 in magnitude, split multiply
module ntt4_red_wide import ntt4_pkg::*; (
  input  logic        clk,
  input  mod_cfg_t    mod_cfg,
  input  logic [61:0] mag,
  input  logic        neg,
  output residue_t    res
);

  logic [61:0] pp_hh;
  logic [61:0] pp_hl;
  logic [61:0] pp_lh;
  logic [61:0] pp_ll;
  logic [31:0] x1;
  logic        n1;
  logic [63:0] t1;
  logic [31:0] hh2;
  logic [31:0] x2;
  logic        n2;
  logic [31:0] q3;
  logic [31:0] x3;
  logic        n3;

  // 31-bit halves of operand and reciprocal
  always_ff @(posedge clk) begin
    pp_hh <= {31'd0, mag[61:31]} * {31'd0, mod_cfg.mu[61:31]};
    pp_hl <= {31'd0, mag[61:31]} * {31'd0, mod_cfg.mu[30:0]};
    pp_lh <= {31'd0, mag[30:0]}  * {31'd0, mod_cfg.mu[61:31]};
    pp_ll <= {31'd0, mag[30:0]}  * {31'd0, mod_cfg.mu[30:0]};
    x1    <= mag[31:0];
    n1    <= neg;
  end

  // middle column with the carry out of the low product
  always_ff @(posedge clk) begin
    t1  <= {2'd0, pp_hl} + {2'd0, pp_lh} + {33'd0, pp_ll[61:31]};
    hh2 <= pp_hh[31:0];
    x2  <= x1;
    n2  <= n1;
  end

  // only the low quotient bits matter for the remainder
  always_ff @(posedge clk) begin
    q3 <= hh2 + t1[62:31];
    x3 <= x2;
    n3 <= n2;
  end

  ntt4_red_tail u_tail (
    .clk     (clk),
    .mod_cfg (mod_cfg),
    .x_lo    (x3),
    .q       (q3),
    .neg     (n3),
    .res     (res)
  );

endmodule
